FILE: hdl/pat_pkg.sv
// shared types and constants of the pending ack tracker
package pat_pkg;

   localparam int SLOTS_DEF = 16;

   localparam logic [31:0] BROADCAST_NODE = 32'hFFFF_FFFF;

   // delivery status codes
   localparam logic [1:0] ST_SENT      = 2'd0;
   localparam logic [1:0] ST_DELIVERED = 2'd1;
   localparam logic [1:0] ST_FAILED    = 2'd2;

   // input operation codes
   localparam logic OP_NOTE = 1'b0;
   localparam logic OP_ACK  = 1'b1;

   typedef struct packed {
      logic        op;
      logic [31:0] packet_id;
      logic [31:0] dest_node;
      logic        thread_is_direct;
      logic [2:0]  thread_channel;
      logic [31:0] thread_peer;
      logic [31:0] ack_from;
      logic        ack_to_us;
      logic [7:0]  ack_error;
   } req_type;

   typedef struct packed {
      logic [31:0] status_packet_id;
      logic [1:0]  new_status;
      logic [7:0]  fail_code;
      logic        out_is_direct;
      logic [2:0]  out_channel;
      logic [31:0] out_peer;
   } rsp_type;

   // per-slot payload held beside the packet id
   typedef struct packed {
      logic [31:0] dest;
      logic        is_direct;
      logic [2:0]  channel;
      logic [31:0] peer;
   } slot_data_type;

   typedef struct packed {
      logic id_wr_en;
      logic data_wr_en;
      logic id_rd_en;
      logic data_rd_en;
   } ram_ctl_type;

endpackage

FILE: hdl/pat_ram.sv
// generic single write port ram with registered read
module pat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/pat_ctrl.sv
// sequencer: ring writes, linear id search, status decision and slot release
module pat_ctrl #(
   parameter int SLOTS = pat_pkg::SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  pat_pkg::req_type           req_word,
   output pat_pkg::ram_ctl_type       ram_ctl,
   output logic [$clog2(SLOTS)-1:0]   wr_addr,
   output logic [31:0]                id_wr_data,
   output pat_pkg::slot_data_type     data_wr_data,
   output logic [$clog2(SLOTS)-1:0]   id_rd_addr,
   input  logic [31:0]                id_rd_data,
   output logic [$clog2(SLOTS)-1:0]   data_rd_addr,
   input  pat_pkg::slot_data_type     data_rd_data,
   input  logic                       out_free,
   output logic                       emit,
   output pat_pkg::rsp_type           rsp_word
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FETCH,
      S_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      pid_ff, pid_in;
   logic [31:0]      from_ff, from_in;
   logic [7:0]       err_ff, err_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0] hit_ff, hit_in;
   logic [IDX_W-1:0] wptr_ff, wptr_in;
   logic [SLOTS-1:0] valid_ff, valid_in;

   logic       accept;
   logic       issue;
   logic       match;
   logic [1:0] status;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign issue     = (scan_ff < CNT_W'(SLOTS));
   assign match     = pend_ff && valid_ff[cmp_idx_ff] && (id_rd_data == pid_ff);

   always_comb begin
      if (err_ff != 8'd0) begin
         status = pat_pkg::ST_FAILED;
      end else if ((data_rd_data.dest == pat_pkg::BROADCAST_NODE) ||
                   (data_rd_data.dest == from_ff)) begin
         status = pat_pkg::ST_DELIVERED;
      end else begin
         status = pat_pkg::ST_SENT;
      end
   end

   assign wr_addr                = wptr_ff;
   assign id_wr_data             = req_word.packet_id;
   assign data_wr_data.dest      = req_word.dest_node;
   assign data_wr_data.is_direct = req_word.thread_is_direct;
   assign data_wr_data.channel   = req_word.thread_channel;
   assign data_wr_data.peer      = req_word.thread_peer;
   assign id_rd_addr             = scan_ff[IDX_W-1:0];
   assign data_rd_addr           = hit_ff;

   assign rsp_word.status_packet_id = pid_ff;
   assign rsp_word.new_status       = status;
   assign rsp_word.fail_code        = err_ff;
   assign rsp_word.out_is_direct    = data_rd_data.is_direct;
   assign rsp_word.out_channel      = data_rd_data.channel;
   assign rsp_word.out_peer         = data_rd_data.peer;

   always_comb begin
      state_in   = state_ff;
      pid_in     = pid_ff;
      from_in    = from_ff;
      err_in     = err_ff;
      scan_in    = scan_ff;
      pend_in    = pend_ff;
      cmp_idx_in = cmp_idx_ff;
      hit_in     = hit_ff;
      wptr_in    = wptr_ff;
      valid_in   = valid_ff;
      ram_ctl    = '0;
      emit       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_word.op == pat_pkg::OP_NOTE)) begin
               ram_ctl.id_wr_en   = 1'b1;
               ram_ctl.data_wr_en = 1'b1;
               valid_in[wptr_ff]  = 1'b1;
               wptr_in = (wptr_ff == IDX_W'(SLOTS - 1)) ? '0 : wptr_ff + IDX_W'(1);
            end else if (accept && req_word.ack_to_us && (req_word.packet_id != 32'd0)) begin
               pid_in   = req_word.packet_id;
               from_in  = req_word.ack_from;
               err_in   = req_word.ack_error;
               scan_in  = '0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // one read issued per cycle, compared the cycle after
            ram_ctl.id_rd_en = issue;
            pend_in          = issue;
            cmp_idx_in       = scan_ff[IDX_W-1:0];
            if (issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (match) begin
               hit_in   = cmp_idx_ff;
               state_in = S_FETCH;
            end else if (!pend_ff && !issue) begin
               state_in = S_IDLE;
            end
         end
         S_FETCH: begin
            ram_ctl.data_rd_en = 1'b1;
            state_in           = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               emit = 1'b1;
               if (status != pat_pkg::ST_SENT) begin
                  valid_in[hit_ff] = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pid_ff     <= pid_in;
      from_ff    <= from_in;
      err_ff     <= err_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_ff     <= hit_in;
      if (reset) begin
         state_ff <= S_IDLE;
         scan_ff  <= '0;
         pend_ff  <= 1'b0;
         wptr_ff  <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         pend_ff  <= pend_in;
         wptr_ff  <= wptr_in;
         valid_ff <= valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_note_marks_slot: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_word.op == pat_pkg::OP_NOTE)) |=> valid_ff[$past(wptr_ff)])
      else $error("noted slot not marked live");

   a_final_status_frees: assert property (@(posedge clock) disable iff (reset)
      (emit && (status != pat_pkg::ST_SENT)) |=> !valid_ff[$past(hit_ff)])
      else $error("delivered or failed slot still live");

   a_sent_keeps_slot: assert property (@(posedge clock) disable iff (reset)
      (emit && (status == pat_pkg::ST_SENT)) |=> valid_ff[$past(hit_ff)])
      else $error("relayed slot released");

   a_match_only_scanning: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> $past(state_ff == S_SCAN))
      else $error("fetch entered without a search hit");
`endif

endmodule

FILE: hdl/pending_ack_tracker_top.sv
// pending ack tracker: slot memories, sequencer and result register
//
// Channels: req_* carries one word per accepted item (valid high, stall low).
// op note stores packet id, destination and thread in the slot under the ring
// pointer and overwrites the oldest entry; op ack searches the slots for the
// request id and, on a hit, sends one rsp_* word with status and stored thread.
// Notes, acks not to us, id zero and misses give no response word.
// An ack to us with a nonzero id searches with one id memory read per slot,
// each compared in the cycle after its read; on a hit it then reads the slot
// data and loads the result register. The search ends at the lowest matching
// slot. The id memory port sets the pace of the search. req_stall is high
// while an ack is busy.
// The result register holds one word; the next item is taken while it waits.
// If rsp_stall holds the register full, a new hit waits until it drains.
// Reset (synchronous) frees all slots, zeroes the ring pointer and empties the
// result register; no clearing pass is needed.
module pending_ack_tracker_top #(
   parameter int SLOTS = pat_pkg::SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_packet_id,
   input  logic [31:0] req_dest_node,
   input  logic        req_thread_is_direct,
   input  logic [2:0]  req_thread_channel,
   input  logic [31:0] req_thread_peer,
   input  logic [31:0] req_ack_from,
   input  logic        req_ack_to_us,
   input  logic [7:0]  req_ack_error,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_status_packet_id,
   output logic [1:0]  rsp_new_status,
   output logic [7:0]  rsp_fail_code,
   output logic        rsp_out_is_direct,
   output logic [2:0]  rsp_out_channel,
   output logic [31:0] rsp_out_peer
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int SD_W  = $bits(pat_pkg::slot_data_type);

   pat_pkg::req_type       req_word;
   pat_pkg::ram_ctl_type   ram_ctl;
   pat_pkg::rsp_type       ctrl_rsp;
   pat_pkg::rsp_type       rsp_word_ff, rsp_word_in;
   pat_pkg::slot_data_type data_wr_data;
   pat_pkg::slot_data_type data_rd_data;

   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] id_rd_addr;
   logic [IDX_W-1:0] data_rd_addr;
   logic [31:0]      id_wr_data;
   logic [31:0]      id_rd_data;
   logic [SD_W-1:0]  data_rd_bits;
   logic             emit;
   logic             out_free;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_word.op               = req_op;
   assign req_word.packet_id        = req_packet_id;
   assign req_word.dest_node        = req_dest_node;
   assign req_word.thread_is_direct = req_thread_is_direct;
   assign req_word.thread_channel   = req_thread_channel;
   assign req_word.thread_peer      = req_thread_peer;
   assign req_word.ack_from         = req_ack_from;
   assign req_word.ack_to_us        = req_ack_to_us;
   assign req_word.ack_error        = req_ack_error;

   pat_ram #(
      .WIDTH (32),
      .DEPTH (SLOTS)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.id_wr_en),
      .wr_addr (wr_addr),
      .wr_data (id_wr_data),
      .rd_en   (ram_ctl.id_rd_en),
      .rd_addr (id_rd_addr),
      .rd_data (id_rd_data)
   );

   pat_ram #(
      .WIDTH (SD_W),
      .DEPTH (SLOTS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.data_wr_en),
      .wr_addr (wr_addr),
      .wr_data (data_wr_data),
      .rd_en   (ram_ctl.data_rd_en),
      .rd_addr (data_rd_addr),
      .rd_data (data_rd_bits)
   );

   assign data_rd_data = data_rd_bits;

   pat_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .ram_ctl      (ram_ctl),
      .wr_addr      (wr_addr),
      .id_wr_data   (id_wr_data),
      .data_wr_data (data_wr_data),
      .id_rd_addr   (id_rd_addr),
      .id_rd_data   (id_rd_data),
      .data_rd_addr (data_rd_addr),
      .data_rd_data (data_rd_data),
      .out_free     (out_free),
      .emit         (emit),
      .rsp_word     (ctrl_rsp)
   );

   // result register, free when empty or draining this cycle
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   assign rsp_word_in  = emit ? ctrl_rsp : rsp_word_ff;

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status_packet_id = rsp_word_ff.status_packet_id;
   assign rsp_new_status       = rsp_word_ff.new_status;
   assign rsp_fail_code        = rsp_word_ff.fail_code;
   assign rsp_out_is_direct    = rsp_word_ff.out_is_direct;
   assign rsp_out_channel      = rsp_word_ff.out_channel;
   assign rsp_out_peer         = rsp_word_ff.out_peer;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a word not yet taken");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_valid_ff && (rsp_word_ff == $past(ctrl_rsp))))
      else $error("result register missed a word");
`endif

endmodule
